FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define FFBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define FFBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ffbs_pkg.sv
`timescale 1ns / 1ps

package ffbs_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int BLK_IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE  = 2'd0,
    CFG_GRAN_LOG2   = 2'd1,
    CFG_LOCAL_MASK  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_OPENED  = 2'd1,
    ST_NO_TYPE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] req_size;
    logic [4:0]  align_log2;
    logic [31:0] type_mask;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  block_number;
    logic [31:0] byte_offset;
    logic [4:0]  chosen_type;
    logic [31:0] opened_size;
  } res_t;

  // One block table entry: memory type and bytes still free.
  typedef struct packed {
    logic [4:0]  btype;
    logic [31:0] free;
  } entry_t;

  // Fit unit to sequencer.
  typedef struct packed {
    logic                 busy;
    logic                 hit;
    logic [BLK_IDX_W-1:0] idx;
    logic [31:0]          off;
    logic [4:0]           btype;
    logic [31:0]          new_free;
  } fit_res_t;

  // 2^g - 1 as a 33-bit mask.
  function automatic logic [32:0] low_mask(input logic [4:0] g);
    logic [32:0] m;
    m = '0;
    for (int k = 0; k < 33; k++) begin
      m[k] = (k < int'(g));
    end
    return m;
  endfunction

  function automatic logic [3:0] to_blk_num(input logic [BLK_IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[3:0];
  endfunction

endpackage

FILE: hw/rtl/ffbs_ram.sv
`timescale 1ns / 1ps

module ffbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ffbs_fit_unit.sv
`timescale 1ns / 1ps

// Three-stage fit check, one block entry per cycle:
// fill start, aligned offset, room left after the request.
module ffbs_fit_unit import ffbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 flush,
  input  logic [31:0]          block_size,
  input  logic [33:0]          rem,
  input  logic [4:0]           align_log2,
  input  logic [31:0]          type_mask,
  input  logic                 rd_valid,
  input  logic [BLK_IDX_W-1:0] rd_idx,
  input  entry_t               rd_entry,
  output fit_res_t             res
);

  logic                 s1_valid, s2_valid, s3_valid;
  logic [BLK_IDX_W-1:0] s1_idx, s2_idx, s3_idx;
  logic [4:0]           s1_btype, s2_btype, s3_btype;
  logic [31:0]          s1_start;
  logic [32:0]          s2_off;
  logic                 s2_ok, s3_ok;
  logic [31:0]          s3_off;
  logic [34:0]          s3_diff;
  logic [32:0]          amask;

  assign amask = low_mask(align_log2);

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= rd_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    // start wraps at 32 bits, as the fill level does
    s1_idx   <= rd_idx;
    s1_btype <= rd_entry.btype;
    s1_start <= block_size - rd_entry.free;

    s2_idx   <= s1_idx;
    s2_btype <= s1_btype;
    s2_ok    <= type_mask[s1_btype];
    s2_off   <= ({1'b0, s1_start} + amask) & ~amask;

    // rem = block_size - size; fits when rem - off > 0
    s3_idx   <= s2_idx;
    s3_btype <= s2_btype;
    s3_ok    <= s2_ok;
    s3_off   <= s2_off[31:0];
    s3_diff  <= {rem[33], rem} - {2'b00, s2_off};
  end

  always_comb begin
    res.busy     = s1_valid | s2_valid;
    res.hit      = s3_valid && s3_ok && !s3_diff[34] && (s3_diff != '0);
    res.idx      = s3_idx;
    res.off      = s3_off;
    res.btype    = s3_btype;
    res.new_free = s3_diff[31:0];
  end

endmodule

FILE: hw/rtl/first_fit_block_suballocator_core.sv
`timescale 1ns / 1ps
// A hit on block k ends the scan at that block; a miss reads every held block and then
// tries to open a new one.
// One request at a time: a new one is taken once the result is loaded into the output
// register, which waits while an earlier result is still stalled by out_ready.
// Reset (rst, synchronous): block table emptied, config back to defaults, no result held.
// Table memory contents are not cleared; only entries below the block count are read.
module first_fit_block_suballocator_core import ffbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Sequencer: round the size, work out room and type, scan the table, open, hand over.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_PREP  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_OPEN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Configuration
  logic [31:0] block_size;
  logic [4:0]  gran_log2;
  logic [31:0] local_mask;

  // Per-request working registers
  req_t        req;
  logic [32:0] size;       // rounded request size, may reach 2^32
  logic [33:0] rem;        // block_size - size, two's complement
  logic [4:0]  ty;         // lowest allowed device-local type
  logic        cand_nz;
  res_t        res;

  // Table state
  logic [CNT_W-1:0]     block_count;
  logic [CNT_W-1:0]     issue_idx;
  logic                 rd_valid;
  logic [BLK_IDX_W-1:0] rd_idx;
  entry_t               rd_entry;

  // Comb
  logic [32:0]          gmask;
  logic [32:0]          size_next;
  logic [33:0]          rem_next;
  logic [31:0]          cand;
  logic [31:0]          cand_low;
  logic [4:0]           ty_next;
  logic                 issue;
  logic                 scan_empty;
  logic                 open_ok;
  logic [31:0]          open_free;
  logic [31:0]          open_size;
  logic                 ram_we;
  logic [BLK_IDX_W-1:0] ram_waddr;
  entry_t               ram_wdata;
  logic                 fit_flush;
  fit_res_t             fit;
  logic                 out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Config writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= 32'd16777216;
      gran_log2  <= 5'd10;
      local_mask <= 32'hFFFF_FFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size <= cfg_data;
        CFG_GRAN_LOG2:  gran_log2  <= cfg_data[4:0];
        CFG_LOCAL_MASK: local_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gmask     = low_mask(gran_log2);
    size_next = ({1'b0, req.req_size} + gmask) & ~gmask;
    rem_next  = {2'b00, block_size} - {1'b0, size};

    // lowest set bit of the allowed device-local types
    cand      = req.type_mask & local_mask;
    cand_low  = cand & (~cand + 32'd1);
    ty_next   = '0;
    for (int k = 0; k < 32; k++) begin
      if (cand_low[k]) begin
        ty_next = ty_next | 5'(k);
      end
    end

    issue      = (state == S_SCAN) && (issue_idx < block_count);
    scan_empty = !issue && !rd_valid && !fit.busy;
    fit_flush  = (state == S_SCAN) && fit.hit;

    // Type search goes first, so a full table with no type still reports no type.
    open_ok   = cand_nz && (block_count < CNT_W'(MAX_BLOCKS));
    // rem >= 0: request fits in a normal block; otherwise the block is the request itself
    open_free = rem[33] ? 32'd0 : rem[31:0];
    open_size = rem[33] ? (size[32] ? 32'hFFFF_FFFF : size[31:0]) : block_size;

    ram_we    = fit_flush || ((state == S_OPEN) && open_ok);
    ram_waddr = fit_flush ? fit.idx : block_count[BLK_IDX_W-1:0];
    if (fit_flush) begin
      ram_wdata.btype = fit.btype;
      ram_wdata.free  = fit.new_free;
    end else begin
      ram_wdata.btype = ty;
      ram_wdata.free  = open_free;
    end

    out_load = (state == S_DONE) && (!out_valid || out_ready);
  end

  ffbs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx[BLK_IDX_W-1:0]),
    .rdata (rd_entry)
  );

  ffbs_fit_unit u_fit (
    .clk        (clk),
    .rst        (rst),
    .flush      (fit_flush),
    .block_size (block_size),
    .rem        (rem),
    .align_log2 (req.align_log2),
    .type_mask  (req.type_mask),
    .rd_valid   (rd_valid),
    .rd_idx     (rd_idx),
    .rd_entry   (rd_entry),
    .res        (fit)
  );

  // Sequencer and table control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      issue_idx   <= '0;
      rd_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          state <= S_PREP;
        end
        S_PREP: begin
          issue_idx <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          // one table read per cycle, in block order
          rd_valid <= issue;
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          // first hit wins; younger reads in flight are dropped
          if (fit.hit) begin
            rd_valid <= 1'b0;
            state    <= S_DONE;
          end else if (scan_empty) begin
            state <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (open_ok) begin
            block_count <= block_count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state    <= S_IDLE;
          rd_valid <= 1'b0;
        end
      endcase
    end
  end

  // Result register: holds until the transfer, parting the two sides.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[BLK_IDX_W-1:0];
    if ((state == S_IDLE) && in_valid) begin
      req <= in_data;
    end
    if (state == S_ROUND) begin
      size <= size_next;
    end
    if (state == S_PREP) begin
      rem     <= rem_next;
      ty      <= ty_next;
      cand_nz <= (cand != '0);
    end
    if (fit_flush) begin
      res.status       <= ST_PLACED;
      res.block_number <= to_blk_num(fit.idx);
      res.byte_offset  <= fit.off;
      res.chosen_type  <= fit.btype;
      res.opened_size  <= '0;
    end else if (state == S_OPEN) begin
      if (!cand_nz) begin
        res <= '{status: ST_NO_TYPE, block_number: '0, byte_offset: '0,
                 chosen_type: '0, opened_size: '0};
      end else if (!open_ok) begin
        res <= '{status: ST_FULL, block_number: '0, byte_offset: '0,
                 chosen_type: '0, opened_size: '0};
      end else begin
        res.status       <= ST_OPENED;
        res.block_number <= to_blk_num(block_count[BLK_IDX_W-1:0]);
        res.byte_offset  <= '0;
        res.chosen_type  <= ty;
        res.opened_size  <= open_size;
      end
    end
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

FILE: hw/rtl/ffbs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffbs_checker import ffbs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input req_t        in_data,
  input logic        out_valid,
  input logic        out_ready,
  input res_t        out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);

  logic in_xfer;
  logic out_stall;
  logic out_err;
  logic err_zero;
  logic placed_bad;
  logic opened_bad;

  assign in_xfer    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign out_err    = out_valid &&
                      ((out_data.status == ST_NO_TYPE) || (out_data.status == ST_FULL));
  assign err_zero   = (out_data.block_number == '0) && (out_data.byte_offset == '0) &&
                      (out_data.chosen_type == '0) && (out_data.opened_size == '0);
  assign placed_bad = out_valid && (out_data.status == ST_PLACED) &&
                      (out_data.opened_size != '0);
  assign opened_bad = out_valid && (out_data.status == ST_OPENED) &&
                      (out_data.byte_offset != '0);

  // one request in flight: no second transfer straight after the first
  `FFBS_ASSERT_NXT(a_one_in_flight, clk, rst, in_xfer, !in_ready, "second request taken")
  `FFBS_ASSERT_IMP(a_err_zero, clk, rst, out_err, err_zero, "error result not zeroed")
  `FFBS_ASSERT_IMP(a_kind_fields, clk, rst, 1'b1, !placed_bad && !opened_bad, "bad fields")
  `FFBS_ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_data), "out drop")

endmodule

bind first_fit_block_suballocator_core ffbs_checker u_ffbs_checker (.*);
